// ===== design/swik_pkg.sv =====
// shared constants and tables for the steered wheel kinematics block
package swik_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ANGLE_W = 18;
  localparam int unsigned CAND_W = 20;
  localparam int unsigned CORD_W = 36;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned TAB_LEN = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_USE_TOL = 3'd6;

  localparam logic signed [CAND_W-1:0] PI_Q12 = 20'sd12868;
  localparam logic signed [CAND_W-1:0] TWO_PI_Q12 = 20'sd25736;
  localparam logic signed [CAND_W-1:0] FOUR_PI_Q12 = 20'sd51472;
  localparam logic signed [CORD_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [FIELD_W-1:0] YAW_DEADBAND = 16'sd40;
  localparam logic signed [23:0] SPIN_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SPIN_MIN = 24'sh800000;
  localparam logic signed [1:0] DIR_FWD = 2'sb01;
  localparam logic signed [1:0] DIR_REV = 2'sb11;
  localparam logic signed [1:0] DIR_NONE = 2'sb00;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0: r = 32'd843314856;
      5'd1: r = 32'd497837829;
      5'd2: r = 32'd263043836;
      5'd3: r = 32'd133525158;
      5'd4: r = 32'd67021686;
      5'd5: r = 32'd33543515;
      5'd6: r = 32'd16775850;
      5'd7: r = 32'd8388437;
      5'd8: r = 32'd4194282;
      5'd9: r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      5'd24: r = 32'd63;
      5'd25: r = 32'd31;
      5'd26: r = 32'd15;
      5'd27: r = 32'd7;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/swik_cordic.sv =====
// iterative vectoring cordic giving the negated wheel angle in q6.12
module swik_cordic import swik_pkg::*; #(
  parameter int STEPS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [32:0]        x_in,
  input  logic signed [31:0]        y_in,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [CORD_W-1:0] x, y, z;
  logic [4:0] step;
  logic busy;
  logic signed [CORD_W-1:0] dx, dy, zt, x0, y0, zr;

  assign dx = x >>> step;
  assign dy = y >>> step;
  assign zt = CORD_W'(signed'({4'b0, atan_entry(step)}));
  assign x0 = CORD_W'(x_in);
  assign y0 = CORD_W'(y_in);
  assign zr = (z + 36'sd131072) >>> 18;
  assign angle = ANGLE_W'(-zr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      if (x0 < 0) begin
        x <= -x0;
        y <= -y0;
        z <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dy;
        y <= y - dx;
        z <= z + zt;
      end else begin
        x <= x - dy;
        y <= y + dx;
        z <= z - zt;
      end
      step <= step + 5'd1;
      if (step == 5'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== design/swik_root_div.sv =====
// iterative square root of the squared speed, then restoring divide by the radius
module swik_root_div import swik_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       sq,
  input  logic [14:0]       radius,
  output logic              done,
  output logic [ROOT_W-1:0] quot
);

  logic [63:0] n, res, bitv, trial;
  logic [14:0] rem;
  logic [15:0] rtry;
  logic [5:0] cnt;
  logic busy, div_phase;

  assign trial = res + bitv;
  assign rtry = {rem, quot[ROOT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      div_phase <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      div_phase <= 1'b0;
      cnt <= '0;
      n <= sq;
      res <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (!div_phase) begin
        if (n >= trial) begin
          n <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (cnt == 6'd31) begin
          div_phase <= 1'b1;
          cnt <= 6'd0;
        end
      end else begin
        if (cnt == 6'd0) begin
          rem <= '0;
          quot <= res[ROOT_W-1:0];
        end else begin
          if (rtry >= {1'b0, radius}) begin
            rem <= 15'(rtry - {1'b0, radius});
            quot <= {quot[ROOT_W-2:0], 1'b1};
          end else begin
            rem <= rtry[14:0];
            quot <= {quot[ROOT_W-2:0], 1'b0};
          end
          if (cnt == 6'd32) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/steered_wheel_inverse_kinematics_top.sv =====
// top level: config registers, shared multiplier, sequencer, steer choice and spin
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: forward_speed, yaw_rate, measured_steer
// m_       out  m_tvalid/m_tready    m_tdata: steer_angle, wheel_spin, direction
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time; the square root and the divide of the spin unit (one bit a
// cycle, 32 steps each plus a load step) set the pace, and the cordic and steer
// choice run beside them.
// rst is synchronous and restores the register defaults and clears the held steer
// and direction. s_tready is low from accept until the result is taken on the m_ side.
module steered_wheel_inverse_kinematics_top import swik_pkg::*; #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // forward_speed, yaw_rate, measured_steer
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // steer_angle, wheel_spin, direction, zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CHECK, ST_CORDIC, ST_SELECT, ST_COMMIT, ST_ROOT, ST_OUT
  } state_t;

  state_t state;
  logic signed [15:0] mount_x, mount_y;
  logic [14:0] wheel_radius, max_steer, steer_tolerance, min_speed;
  logic use_tolerance;
  logic signed [15:0] held_steer;
  logic signed [1:0] held_direction;
  logic signed [15:0] v, w, meas;
  logic signed [32:0] vx;
  logic signed [31:0] vy;
  logic [63:0] sum;
  logic [53:0] thr;
  logic [2:0] mcnt;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic deadband_pass;
  logic cord_done, root_done;
  logic signed [ANGLE_W-1:0] cord_angle, a;
  logic [ROOT_W-1:0] quot;
  logic [2:0] k;
  logic best_valid;
  logic signed [CAND_W-1:0] best_c, best_err, cand, err, ms_s;
  logic signed [1:0] best_dir, cand_dir;
  logic cand_ok;
  logic signed [16:0] tol_diff;
  logic signed [23:0] steer_out_spin;
  logic signed [15:0] out_steer;
  logic signed [23:0] out_spin;
  logic signed [1:0] out_dir;

  function automatic logic signed [CAND_W-1:0] mod_two_pi(input logic signed [CAND_W-1:0] t);
    logic signed [CAND_W-1:0] r;
    if (t >= 0) begin
      if (t >= FOUR_PI_Q12) r = t - FOUR_PI_Q12;
      else if (t >= TWO_PI_Q12) r = t - TWO_PI_Q12;
      else r = t;
    end else begin
      if (t <= -FOUR_PI_Q12) r = t + FOUR_PI_Q12;
      else if (t <= -TWO_PI_Q12) r = t + TWO_PI_Q12;
      else r = t;
    end
    return r;
  endfunction

  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata = {6'b0, out_dir, out_spin, out_steer};
  assign deadband_pass = (w > YAW_DEADBAND) || (w < -YAW_DEADBAND);

  always_comb begin
    unique case (mcnt)
      3'd0: begin mul_a = 33'(w); mul_b = 33'(mount_y); end
      3'd1: begin mul_a = 33'(w); mul_b = 33'(mount_x); end
      3'd2: begin mul_a = vx; mul_b = vx; end
      3'd3: begin mul_a = 33'(vy); mul_b = 33'(vy); end
      3'd4: begin
        mul_a = 33'(signed'({6'b0, min_speed, 12'b0}));
        mul_b = 33'(signed'({6'b0, min_speed, 12'b0}));
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  swik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(state == ST_CHECK && sum > {10'b0, thr}),
    .x_in(vx), .y_in(vy), .done(cord_done), .angle(cord_angle)
  );

  swik_root_div u_root (
    .clk(clk), .rst(rst), .start(state == ST_CHECK), .sq(sum),
    .radius(wheel_radius), .done(root_done), .quot(quot)
  );

  always_comb begin
    unique case (k)
      3'd0: cand = CAND_W'(a);
      3'd1: cand = CAND_W'(a) + PI_Q12;
      3'd2: cand = CAND_W'(a) - PI_Q12;
      3'd3: cand = mod_two_pi(CAND_W'(a) + TWO_PI_Q12);
      3'd4: cand = mod_two_pi(CAND_W'(a) + PI_Q12 + TWO_PI_Q12);
      3'd5: cand = mod_two_pi(CAND_W'(a) - PI_Q12 + TWO_PI_Q12);
      default: cand = '0;
    endcase
    cand_dir = (k == 3'd0 || k == 3'd3) ? DIR_FWD : DIR_REV;
    ms_s = CAND_W'(signed'({1'b0, max_steer}));
    cand_ok = !(cand > PI_Q12 || cand < -PI_Q12 || cand > ms_s || cand < -ms_s);
    err = CAND_W'(meas) - cand;
    if (err < 0) err = -err;
  end

  always_comb begin
    tol_diff = 17'(held_steer) - 17'(meas);
    if (tol_diff < 0) tol_diff = -tol_diff;
    if (use_tolerance && tol_diff > 17'(signed'({2'b0, steer_tolerance}))) begin
      steer_out_spin = '0;
    end else if (held_direction == DIR_NONE) begin
      steer_out_spin = '0;
    end else if (wheel_radius == '0) begin
      steer_out_spin = (held_direction == DIR_FWD) ? SPIN_MAX : SPIN_MIN;
    end else if (held_direction == DIR_FWD) begin
      steer_out_spin = (quot > 32'd8388607) ? SPIN_MAX : 24'(quot);
    end else begin
      steer_out_spin = (quot >= 32'd8388608) ? SPIN_MIN : -24'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOUNT_X: mount_x <= cfg_data;
        REG_MOUNT_Y: mount_y <= cfg_data;
        REG_RADIUS: wheel_radius <= cfg_data[14:0];
        REG_MAX_STEER: max_steer <= cfg_data[14:0];
        REG_TOLERANCE: steer_tolerance <= cfg_data[14:0];
        REG_MIN_SPEED: min_speed <= cfg_data[14:0];
        REG_USE_TOL: use_tolerance <= cfg_data[0];
        default: ;
      endcase
    end
    if (rst) begin
      mount_x <= 16'sd1638;
      mount_y <= 16'sd0;
      wheel_radius <= 15'd471;
      max_steer <= 15'd12868;
      steer_tolerance <= 15'd1229;
      min_speed <= 15'd41;
      use_tolerance <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      held_steer <= '0;
      held_direction <= DIR_NONE;
      mcnt <= '0;
      k <= '0;
      best_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            v <= s_tdata[15:0];
            w <= s_tdata[31:16];
            meas <= s_tdata[47:32];
            mcnt <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          mcnt <= mcnt + 3'd1;
          unique case (mcnt)
            3'd1: vx <= 33'(signed'({v, 12'b0}))
                        - (deadband_pass ? mul_p[32:0] : 33'sd0);
            3'd2: vy <= deadband_pass ? mul_p[31:0] : 32'sd0;
            3'd3: sum <= mul_p[63:0];
            3'd4: sum <= sum + mul_p[63:0];
            3'd5: begin
              thr <= mul_p[53:0];
              state <= ST_CHECK;
            end
            default: ;
          endcase
        end
        ST_CHECK: begin
          state <= (sum > {10'b0, thr}) ? ST_CORDIC : ST_ROOT;
        end
        ST_CORDIC: begin
          if (cord_done) begin
            a <= cord_angle;
            k <= '0;
            best_valid <= 1'b0;
            state <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          if (cand_ok && (!best_valid || err < best_err)) begin
            best_valid <= 1'b1;
            best_err <= err;
            best_c <= cand;
            best_dir <= cand_dir;
          end
          k <= k + 3'd1;
          if (k == 3'd5) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (best_valid) begin
            held_steer <= 16'(-best_c);
            held_direction <= best_dir;
          end else begin
            held_steer <= 16'(-a);
            held_direction <= DIR_FWD;
          end
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            out_steer <= held_steer;
            out_spin <= steer_out_spin;
            out_dir <= held_direction;
            m_tvalid <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/swik_checker.sv =====
// checker for the steered wheel block: watches all channels, predicts and compares
`timescale 1ns / 1ps
module swik_checker import swik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [47:0]          m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic signed [15:0] steer;
    logic signed [23:0] spin;
    logic signed [1:0]  dir;
  } wheel_cmd_t;

  wheel_cmd_t cmd_q[$];

  logic signed [15:0] mount_x, mount_y;
  logic [14:0] radius, max_steer, tolerance, min_speed;
  logic use_tol;
  int held_steer, held_dir;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int steer_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 14; i++) begin
      dx = floor_shift(x, i);
      dy = floor_shift(y, i);
      if (y > 0) begin
        x = x + dy;
        y = y - dx;
        z = z + longint'(atan_entry(i[4:0]));
      end else begin
        x = x - dy;
        y = y + dx;
        z = z - longint'(atan_entry(i[4:0]));
      end
    end
    return int'(floor_shift(z + (64'sd1 <<< 17), 18));
  endfunction

  task automatic predict_wheel(input logic [47:0] data);
    longint v, w, vx, vy, sp, mag;
    longint unsigned sum, thr;
    int meas, a, best, best_err, err, m;
    int cand[6];
    int dirs[6];
    wheel_cmd_t r;
    v = longint'($signed(data[15:0]));
    w = longint'($signed(data[31:16]));
    meas = int'($signed(data[47:32]));
    vx = v * 4096;
    vy = 0;
    if (w > 40 || w < -40) begin
      vx = vx - w * longint'(mount_y);
      vy = w * longint'(mount_x);
    end
    sum = longint'(vx * vx) + longint'(vy * vy);
    thr = longint'(min_speed) * 4096;
    thr = thr * thr;
    if (sum > thr) begin
      a = -steer_atan2(vy, vx);
      dirs = '{1, -1, -1, 1, -1, -1};
      cand[0] = a;
      cand[1] = a + 12868;
      cand[2] = a - 12868;
      cand[3] = (a + 25736) % 25736;
      cand[4] = (cand[1] + 25736) % 25736;
      cand[5] = (cand[2] + 25736) % 25736;
      best = -1;
      best_err = 0;
      for (int i = 0; i < 6; i++) begin
        m = cand[i] < 0 ? -cand[i] : cand[i];
        if (!(m > 12868 || m > int'(max_steer))) begin
          err = meas - cand[i];
          if (err < 0) err = -err;
          if (best < 0 || err < best_err) begin
            best = i;
            best_err = err;
          end
        end
      end
      if (best < 0) best = 0;
      held_steer = -cand[best];
      held_dir = dirs[best];
    end
    err = held_steer - meas;
    if (err < 0) err = -err;
    if (use_tol && err > int'(tolerance)) sp = 0;
    else if (held_dir == 0) sp = 0;
    else if (radius == 0) sp = held_dir > 0 ? longint'(SPIN_MAX) : longint'(SPIN_MIN);
    else begin
      mag = longint'(int_sqrt(sum) / longint'(radius));
      sp = held_dir > 0 ? mag : -mag;
      if (sp > longint'(SPIN_MAX)) sp = longint'(SPIN_MAX);
      if (sp < longint'(SPIN_MIN)) sp = longint'(SPIN_MIN);
    end
    r.steer = held_steer[15:0];
    r.spin = sp[23:0];
    r.dir = held_dir[1:0];
    cmd_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] wheel result %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = cmd_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    wheel_cmd_t e;
    if (rst) begin
      mount_x <= 16'sd1638;
      mount_y <= 16'sd0;
      radius <= 15'd471;
      max_steer <= 15'd12868;
      tolerance <= 15'd1229;
      min_speed <= 15'd41;
      use_tol <= 1'b0;
      held_steer = 0;
      held_dir = 0;
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOUNT_X: mount_x <= cfg_data;
          REG_MOUNT_Y: mount_y <= cfg_data;
          REG_RADIUS: radius <= cfg_data[14:0];
          REG_MAX_STEER: max_steer <= cfg_data[14:0];
          REG_TOLERANCE: tolerance <= cfg_data[14:0];
          REG_MIN_SPEED: min_speed <= cfg_data[14:0];
          REG_USE_TOL: use_tol <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_wheel(s_tdata);
      if (m_tvalid && m_tready) begin
        if (cmd_q.size() == 0) begin
          $display("[%0t] wheel result with nothing pending", $time);
          fail_count++;
        end else begin
          e = cmd_q.pop_front();
          if ($signed(m_tdata[15:0]) != e.steer)
            report_mismatch("steer_angle", $signed(m_tdata[15:0]), e.steer);
          if ($signed(m_tdata[39:16]) != e.spin)
            report_mismatch("wheel_spin", $signed(m_tdata[39:16]), e.spin);
          if ($signed(m_tdata[41:40]) != e.dir)
            report_mismatch("direction", $signed(m_tdata[41:40]), e.dir);
          if (m_tdata[47:42] != 6'd0)
            report_mismatch("pad", m_tdata[47:42], 0);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_steered_wheel_inverse_kinematics_top.sv =====
// testbench top for the steered wheel block: clock, stimulus and verdict
`timescale 1ns / 1ps
module tb_steered_wheel_inverse_kinematics_top;
  import swik_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE = 150;
  localparam int STALL_LIMIT = 3000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [47:0] s_tdata, m_tdata;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending;
  bit quiet;
  int stall_cycles;

  steered_wheel_inverse_kinematics_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swik_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure in bursts
  initial begin
    int burst;
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 14);
        m_tready = 1'b0;
        repeat (burst - 1) @(negedge clk);
        @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_wheel_cmd(input logic [15:0] speed, input logic [15:0] yaw,
                                input logic [15:0] meas);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tdata = {meas, yaw, speed};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_wheel_cmd();
    logic [15:0] speed, yaw, meas;
    speed = $urandom;
    yaw = $urandom;
    meas = $urandom;
    case ($urandom_range(0, 3))
      0: speed = 16'($signed($urandom_range(0, 600)) - 300);
      1: yaw = 16'($signed($urandom_range(0, 100)) - 50);
      2: meas = 16'($signed($urandom_range(0, 25736)) - 12868);
      default: ;
    endcase
    send_wheel_cmd(speed, yaw, meas);
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no direction yet, then basic motions at reset settings
    send_wheel_cmd(16'sd0, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sd10, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sd4096, 16'sd0, 16'sd0);
    send_wheel_cmd(-16'sd4096, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sd0, 16'sd40, 16'sd12868);
    send_wheel_cmd(16'sd0, 16'sd41, -16'sd12868);
    send_wheel_cmd(16'sd0, -16'sd41, 16'sd0);
    send_wheel_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_wheel_cmd(16'sh8000, 16'sh8000, 16'sh8000);
    send_wheel_cmd(16'sh8000, 16'sh7FFF, 16'sd0);
    send_wheel_cmd(16'sd0, 16'sh8000, 16'sh7FFF);
    wait_drained();

    // extreme mounts, smallest nonzero radius, no steer range, tight tolerance
    write_reg(REG_MOUNT_X, 16'sh8000);
    write_reg(REG_MOUNT_Y, 16'sh7FFF);
    write_reg(REG_RADIUS, 16'd1);
    write_reg(REG_MAX_STEER, 16'd0);
    write_reg(REG_TOLERANCE, 16'd0);
    write_reg(REG_USE_TOL, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_wheel_cmd(16'sh7FFF, 16'sh7FFF, 16'sd0);
    send_wheel_cmd(16'sd0, 16'sd1000, 16'sd0);
    send_wheel_cmd(-16'sd3000, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sd0, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sh8000, -16'sd500, 16'sh8000);
    wait_drained();

    write_reg(REG_MAX_STEER, 16'h7FFF);
    write_reg(REG_MIN_SPEED, 16'h7FFF);
    write_reg(REG_TOLERANCE, 16'h7FFF);
    write_reg(REG_RADIUS, 16'h7FFF);
    send_wheel_cmd(16'sh7FFF, 16'sd0, 16'sd0);
    send_wheel_cmd(16'sd100, 16'sh7FFF, 16'sd0);
    send_wheel_cmd(16'sh8000, 16'sh8000, 16'sd0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_MOUNT_X, 16'($urandom));
      write_reg(REG_MOUNT_Y, 16'($urandom));
      write_reg(REG_RADIUS, 16'($urandom_range(1, phase < 4 ? 2000 : 32767)));
      write_reg(REG_MAX_STEER, 16'($urandom_range(0, 16000)));
      write_reg(REG_TOLERANCE, 16'($urandom_range(0, 8000)));
      write_reg(REG_MIN_SPEED, 16'($urandom_range(0, phase[0] ? 32767 : 200)));
      write_reg(REG_USE_TOL, 16'($urandom_range(0, 1)));
      if (phase == 7) quiet = 1'b1;
      repeat (48) random_wheel_cmd();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
